[rtl/apu_pkg.sv]
// Shared types, constants and state encodings for the Adam parameter update block.
`timescale 1ns / 1ps
`default_nettype none

package apu_pkg;

    localparam int GRAD_W  = 48;
    localparam int VEL_W   = 64;
    localparam int PARAM_W = 32;
    localparam int RATE_W  = 32;
    localparam int IDX_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indices on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_ONE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_TWO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LR_INIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LR_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LR_DIV       = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MOM,
        ST_VEL,
        ST_SQRT,
        ST_DIV,
        ST_DELTA,
        ST_NEXT,
        ST_EPOCH,
        ST_RDIV,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;     // write zero at the clear address
        logic load;       // capture the input beat, start reading memories
        logic sel_end;    // 0: middle game lane, 1: end game lane
        logic scale;      // scale the gradient of the selected lane
        logic mom;        // update momentum and square
        logic vel;        // velocity update
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic delta;      // compute new delta and write back all three stores
        logic ep_start;   // epoch check
        logic emod_step;  // one bit of epoch remainder
        logic rdiv_start;
        logic rdiv_step;
        logic rdiv_done;
        logic emit;       // move the finished result into the output register
    } t_cmd;

    typedef struct packed {
        logic do_drop;
    } t_stat;

endpackage

`default_nettype wire

[rtl/apu_datapath.sv]
// Datapath: state memories, arithmetic and iterative root and dividers.
`timescale 1ns / 1ps
`default_nettype none

module apu_datapath #(
    parameter int MAX_TERMS = 1024,
    parameter int ADDR_W    = 10
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire apu_pkg::t_cmd               i_cmd,
    output apu_pkg::t_stat                   o_stat,
    input  wire [ADDR_W-1:0]                 i_clr_addr,
    input  wire                              i_cfg_valid,
    input  wire                              i_cfg_ready,
    input  wire [apu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [apu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire [apu_pkg::IDX_W-1:0]         i_term_index,
    input  wire signed [apu_pkg::GRAD_W-1:0] i_grad_mid,
    input  wire signed [apu_pkg::GRAD_W-1:0] i_grad_end,
    input  wire                              i_epoch_last,
    output logic [apu_pkg::IDX_W-1:0]        o_out_index,
    output logic signed [apu_pkg::PARAM_W-1:0] o_param_mid,
    output logic signed [apu_pkg::PARAM_W-1:0] o_param_end,
    output logic                             o_rate_dropped
);
    import apu_pkg::*;

    // configuration
    logic [31:0] r_grad_scale, r_rate;
    logic [15:0] r_beta_one, r_beta_two, r_lr_step, r_lr_div, r_epoch;
    logic        cfg_wr;
    assign cfg_wr = i_cfg_valid && i_cfg_ready;

    // memories
    logic signed [GRAD_W-1:0]  mem_mom_mid [MAX_TERMS];
    logic signed [GRAD_W-1:0]  mem_mom_end [MAX_TERMS];
    logic [VEL_W-1:0]          mem_vel_mid [MAX_TERMS];
    logic [VEL_W-1:0]          mem_vel_end [MAX_TERMS];
    logic signed [PARAM_W-1:0] mem_dlt_mid [MAX_TERMS];
    logic signed [PARAM_W-1:0] mem_dlt_end [MAX_TERMS];

    logic signed [GRAD_W-1:0]  r_rd_mom_mid, r_rd_mom_end;
    logic [VEL_W-1:0]          r_rd_vel_mid, r_rd_vel_end;
    logic signed [PARAM_W-1:0] r_rd_dlt_mid, r_rd_dlt_end;

    logic [ADDR_W-1:0]         r_addr;
    logic                      r_in_range, r_last;
    logic [IDX_W-1:0]          r_index;
    logic signed [GRAD_W-1:0]  r_g_mid, r_g_end;

    // working registers for the lane in flight
    logic [47:0]               r_sprod;
    logic signed [GRAD_W:0]    r_sval;
    logic signed [GRAD_W-1:0]  r_m;
    logic [VEL_W-1:0]          r_q, r_v;
    logic [32:0]               r_root;
    logic [VEL_W-1:0]          r_srem;
    logic [4:0]                r_cnt;
    logic [79:0]               r_num;
    logic [32:0]               r_drem;
    logic [32:0]               r_den;
    logic                      r_mneg;
    logic signed [PARAM_W-1:0] r_new_mid, r_new_end;
    logic                      r_drop;

    logic signed [GRAD_W-1:0]  cur_g, cur_mom;
    logic [VEL_W-1:0]          cur_vel;
    logic signed [PARAM_W-1:0] cur_dlt;
    logic [ADDR_W-1:0]         wr_addr;

    assign cur_g   = i_cmd.sel_end ? r_g_end : r_g_mid;
    assign cur_mom = i_cmd.sel_end ? r_rd_mom_end : r_rd_mom_mid;
    assign cur_vel = i_cmd.sel_end ? r_rd_vel_end : r_rd_vel_mid;
    assign cur_dlt = i_cmd.sel_end ? r_rd_dlt_end : r_rd_dlt_mid;
    assign wr_addr = i_cmd.clr_wr ? i_clr_addr : r_addr;

    // gradient scaling: two partial products (16x32 and 32x32), registered
    logic                g_neg;
    logic [GRAD_W-1:0]   g_mag;
    logic [47:0]         sprod;
    logic signed [GRAD_W:0] s_val;
    assign g_neg = cur_g[GRAD_W-1];
    assign g_mag = g_neg ? (GRAD_W'(0) - cur_g) : cur_g;
    always_comb begin
        logic [63:0] ph, pl;
        ph    = {48'd0, g_mag[47:32]} * {32'd0, r_grad_scale};
        pl    = {32'd0, g_mag[31:0]} * {32'd0, r_grad_scale};
        sprod = 48'(ph + (pl >> 32));
        s_val = g_neg ? $signed({1'b0, sprod}) : -$signed({1'b0, sprod});
    end

    // momentum: floor((b1*m + c1*s) / 2^16), sum is exact before shifting
    logic signed [67:0] m_sum;
    logic [16:0]        c1, c2;
    assign c1 = 17'd65536 - {1'b0, r_beta_one};
    assign c2 = 17'd65536 - {1'b0, r_beta_two};
    assign m_sum = $signed({1'b0, r_beta_one}) * 68'(cur_mom)
                 + $signed({1'b0, c1}) * 68'(r_sval);

    // square of |s|, truncated as the three-term form does
    logic [63:0] q_val;
    always_comb begin
        logic [15:0] sh;
        logic [31:0] sl;
        logic [63:0] sll;
        sh    = r_sprod[47:32];
        sl    = r_sprod[31:0];
        sll   = {32'd0, sl} * {32'd0, sl};
        q_val = ({32'd0, sh} * {32'd0, sh} << 32)
              + ({31'd0, sh, 1'b0} * {32'd0, sl}) + (sll >> 32);
    end

    // velocity
    logic [VEL_W-1:0] nv;
    always_comb begin
        logic [63:0] lo;
        lo = ({48'd0, r_beta_two} * {48'd0, r_v[15:0]})
           + ({47'd0, c2} * {48'd0, r_q[15:0]});
        nv = ({48'd0, r_beta_two} * (r_v >> 16))
           + ({47'd0, c2} * (r_q >> 16)) + (lo >> 16);
    end

    // square root, one result bit per cycle (restoring)
    logic [VEL_W-1:0] sq_v;
    logic [65:0]      sq_trial, sq_rem2;
    assign sq_v     = r_v;
    assign sq_rem2  = {r_srem, sq_v[2*r_cnt+1 -: 2]};
    assign sq_trial = sq_rem2 - {31'd0, r_root, 2'b01};

    // delta
    logic signed [PARAM_W+48:0] nd_full;
    logic signed [PARAM_W-1:0]  nd_sat;
    always_comb begin
        logic signed [PARAM_W+48:0] st;
        st      = $signed({1'b0, r_num});
        nd_full = (PARAM_W+49)'(cur_dlt) - (r_mneg ? -st : st);
        if (nd_full > (PARAM_W+49)'(32'sh7FFFFFFF))
            nd_sat = 32'sh7FFFFFFF;
        else if (nd_full < -(PARAM_W+49)'(64'sd2147483648))
            nd_sat = 32'sh80000000;
        else
            nd_sat = PARAM_W'(nd_full);
    end

    // rate drop divider (40 bits by 16)
    logic [39:0] r_rq;
    logic [15:0] r_rr;
    logic [16:0] rr_shift;
    assign rr_shift = {r_rr, r_rq[39]};

    // epoch remainder against the step count, one bit per cycle
    logic [15:0] r_emq, r_emod;
    logic [16:0] em_shift;
    assign em_shift = {r_emod, r_emq[15]};

    always_ff @(posedge i_clk) begin
        logic [47:0] mm_abs;
        logic [63:0] pa, pb;
        if (!i_rst_n) begin
            r_grad_scale <= 32'd1;
            r_beta_one   <= 16'd58982;
            r_beta_two   <= 16'd65470;
            r_rate       <= 32'd16777216;
            r_lr_step    <= 16'd250;
            r_lr_div     <= 16'd256;
            r_epoch      <= 16'd1;
            r_drop       <= 1'b0;
            o_rate_dropped <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_GRAD_SCALE: r_grad_scale <= i_cfg_data;
                    REG_BETA_ONE:   r_beta_one   <= i_cfg_data[15:0];
                    REG_BETA_TWO:   r_beta_two   <= i_cfg_data[15:0];
                    REG_LR_INIT:    r_rate       <= i_cfg_data;
                    REG_LR_STEP:    r_lr_step    <= i_cfg_data[15:0];
                    REG_LR_DIV:     r_lr_div     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.load)
                r_drop <= 1'b0;
            if (i_cmd.rdiv_done) begin
                r_rate <= (|r_rq[39:32]) ? 32'hFFFFFFFF : r_rq[31:0];
                r_drop <= 1'b1;
            end
            if (i_cmd.emit)
                o_rate_dropped <= r_drop;
            if (i_cmd.ep_start && r_last)
                r_epoch <= r_epoch + 16'd1;
        end

        // out-of-range terms leave the stores untouched
        if (i_cmd.clr_wr || (i_cmd.delta && r_in_range)) begin
            if (!i_cmd.sel_end || i_cmd.clr_wr) begin
                mem_mom_mid[wr_addr] <= i_cmd.clr_wr ? '0 : r_m;
                mem_vel_mid[wr_addr] <= i_cmd.clr_wr ? '0 : r_v;
                mem_dlt_mid[wr_addr] <= i_cmd.clr_wr ? '0 : nd_sat;
            end
            if (i_cmd.sel_end || i_cmd.clr_wr) begin
                mem_mom_end[wr_addr] <= i_cmd.clr_wr ? '0 : r_m;
                mem_vel_end[wr_addr] <= i_cmd.clr_wr ? '0 : r_v;
                mem_dlt_end[wr_addr] <= i_cmd.clr_wr ? '0 : nd_sat;
            end
        end

        if (i_cmd.load) begin
            r_addr     <= ADDR_W'(i_term_index);
            r_index    <= i_term_index;
            r_in_range <= ({22'd0, i_term_index} < 32'(MAX_TERMS));
            r_last     <= i_epoch_last;
            r_g_mid    <= i_grad_mid;
            r_g_end    <= i_grad_end;
        end
        // registered reads from the address captured at load
        r_rd_mom_mid <= mem_mom_mid[r_addr];
        r_rd_mom_end <= mem_mom_end[r_addr];
        r_rd_vel_mid <= mem_vel_mid[r_addr];
        r_rd_vel_end <= mem_vel_end[r_addr];
        r_rd_dlt_mid <= mem_dlt_mid[r_addr];
        r_rd_dlt_end <= mem_dlt_end[r_addr];

        if (i_cmd.scale) begin
            r_sprod <= sprod;
            r_sval  <= s_val;
        end
        if (i_cmd.mom) begin
            r_m <= GRAD_W'(m_sum >>> 16);
            r_q <= q_val;
            r_v <= cur_vel;
        end
        if (i_cmd.vel)
            r_v <= nv;
        if (i_cmd.sqrt_start) begin
            r_root <= '0;
            r_srem <= '0;
            r_cnt  <= 5'd31;
            r_mneg <= r_m[GRAD_W-1];
        end
        if (i_cmd.sqrt_step) begin
            if (!sq_trial[65]) begin
                r_srem <= 64'(sq_trial);
                r_root <= {r_root[31:0], 1'b1};
            end else begin
                r_srem <= 64'(sq_rem2);
                r_root <= {r_root[31:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
        end
        if (i_cmd.div_start) begin
            mm_abs = r_mneg ? -r_m : r_m;
            pa = {32'd0, r_rate} * {48'd0, mm_abs[47:32]};
            pb = {32'd0, r_rate} * {32'd0, mm_abs[31:0]};
            r_num  <= 80'({pa, 8'd0}) + 80'(pb >> 24);
            r_drem <= '0;
            r_den  <= r_root + 33'd1;
        end
        if (i_cmd.div_step) begin
            if ({r_drem, r_num[79]} >= {1'b0, r_den}) begin
                r_drem <= 33'({r_drem, r_num[79]} - {1'b0, r_den});
                r_num  <= {r_num[78:0], 1'b1};
            end else begin
                r_drem <= 33'({r_drem, r_num[79]});
                r_num  <= {r_num[78:0], 1'b0};
            end
        end
        if (i_cmd.delta) begin
            if (i_cmd.sel_end) r_new_end <= nd_sat;
            else r_new_mid <= nd_sat;
        end
        if (i_cmd.ep_start) begin
            r_emq  <= r_epoch;
            r_emod <= '0;
        end
        if (i_cmd.emod_step) begin
            if (em_shift >= {1'b0, r_lr_step})
                r_emod <= 16'(em_shift - {1'b0, r_lr_step});
            else
                r_emod <= em_shift[15:0];
            r_emq <= {r_emq[14:0], 1'b0};
        end
        if (i_cmd.rdiv_start) begin
            r_rq <= {r_rate, 8'd0};
            r_rr <= '0;
        end
        if (i_cmd.rdiv_step) begin
            if (rr_shift >= {1'b0, r_lr_div}) begin
                r_rr <= 16'(rr_shift - {1'b0, r_lr_div});
                r_rq <= {r_rq[38:0], 1'b1};
            end else begin
                r_rr <= rr_shift[15:0];
                r_rq <= {r_rq[38:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            o_param_mid <= r_in_range ? r_new_mid : '0;
            o_param_end <= r_in_range ? r_new_end : '0;
            o_out_index <= r_index;
        end
    end

    // a zero epoch count gives a zero remainder, so it counts as a hit
    assign o_stat.do_drop = r_last && (r_lr_step != 16'd0) && (r_lr_div != 16'd0)
                         && (r_emod == 16'd0);

endmodule

`default_nettype wire

[rtl/apu_ctrl.sv]
// Controller: sequences clearing, the two lane updates, the epoch step, the rate drop and the output.
`timescale 1ns / 1ps
`default_nettype none

module apu_ctrl #(
    parameter int ADDR_W = 10,
    parameter int DEPTH  = 1024
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire                i_ready,
    input  wire apu_pkg::t_stat i_stat,
    output apu_pkg::t_cmd      o_cmd,
    output logic [ADDR_W-1:0]  o_clr_addr
);
    import apu_pkg::*;

    t_state r_state, n_state;
    logic [ADDR_W:0] r_clr, n_clr;
    logic [6:0]      r_cnt, n_cnt;
    logic            r_lane, n_lane;
    logic            r_ov, n_ov;

    assign o_clr_addr = r_clr[ADDR_W-1:0];
    assign o_valid    = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_lane  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_lane  <= n_lane;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cnt   = r_cnt;
        n_lane  = r_lane;
        n_ov    = r_ov && !i_ready;
        o_cmd   = '0;
        o_cmd.sel_end = r_lane;
        o_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == (ADDR_W+1)'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                // a waiting result sits in the output register, so input is still taken
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_lane  = 1'b0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.scale = 1'b1;
                n_state = ST_MOM;
            end
            ST_MOM: begin
                o_cmd.mom = 1'b1;
                n_state = ST_VEL;
            end
            ST_VEL: begin
                o_cmd.vel = 1'b1;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_start = 1'b1;
                n_cnt   = 7'd32;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt > 7'd0) begin
                    o_cmd.sqrt_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                    if (r_cnt == 7'd1) n_cnt = 7'd0;
                end
                if (r_cnt == 7'd0) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt   = 7'd80;
                    n_state = ST_DELTA;
                end
            end
            ST_DELTA: begin
                if (r_cnt != 7'd0) begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    o_cmd.delta = 1'b1;
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (!r_lane) begin
                    n_lane  = 1'b1;
                    n_state = ST_READ;
                end else begin
                    o_cmd.ep_start = 1'b1;
                    n_cnt   = 7'd16;
                    n_state = ST_EPOCH;
                end
            end
            ST_EPOCH: begin
                if (r_cnt != 7'd0) begin
                    o_cmd.emod_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                end else if (i_stat.do_drop) begin
                    o_cmd.rdiv_start = 1'b1;
                    n_cnt   = 7'd40;
                    n_state = ST_RDIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_RDIV: begin
                if (r_cnt != 7'd0) begin
                    o_cmd.rdiv_step = 1'b1;
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    o_cmd.rdiv_done = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait until the previous result has left the output register
                if (!r_ov || i_ready) begin
                    o_cmd.emit = 1'b1;
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/adam_param_update_core.sv]
// Top level of the Adam parameter update block.
//  channel | direction | handshake
//  cfg     | in        | i_cfg_valid / o_cfg_ready, index + data
//  in      | in        | i_valid / o_ready
//  out     | out       | o_valid / i_ready
// A beat is accepted, then worked through two lanes (scale, momentum, velocity,
// 32-step root, 80-step divider), a 16-step epoch remainder, a rate drop when
// due and the output move before its result shows on o_valid. A new beat is
// taken only once the previous one has reached the output register.
// After reset a clearing pass over all MAX_TERMS addresses zeroes the stores; no beat
// is taken meanwhile. A stalled result waits in the output register while the
// next beat is worked; that one then waits until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module adam_param_update_core #(
    parameter int MAX_TERMS = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [apu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [apu_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire [apu_pkg::IDX_W-1:0]           i_term_index,
    input  wire signed [apu_pkg::GRAD_W-1:0]   i_grad_mid,
    input  wire signed [apu_pkg::GRAD_W-1:0]   i_grad_end,
    input  wire                                i_epoch_last,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [apu_pkg::IDX_W-1:0]          o_out_index,
    output logic signed [apu_pkg::PARAM_W-1:0] o_param_mid,
    output logic signed [apu_pkg::PARAM_W-1:0] o_param_end,
    output logic                               o_rate_dropped
);
    import apu_pkg::*;

    localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    t_cmd  cmd;
    t_stat stat;
    logic [ADDR_W-1:0] clr_addr;

    assign o_cfg_ready = 1'b1;

    apu_ctrl #(.ADDR_W(ADDR_W), .DEPTH(MAX_TERMS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_stat(stat), .o_cmd(cmd), .o_clr_addr(clr_addr)
    );

    apu_datapath #(.MAX_TERMS(MAX_TERMS), .ADDR_W(ADDR_W)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .i_clr_addr(clr_addr),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_term_index, .i_grad_mid, .i_grad_end, .i_epoch_last,
        .o_out_index, .o_param_mid, .o_param_end, .o_rate_dropped
    );

endmodule

`default_nettype wire

[rtl/apu_checker.sv]
// Port-level checker for the Adam parameter update block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module apu_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_valid,
    input wire o_ready,
    input wire o_valid,
    input wire i_ready,
    input wire [apu_pkg::IDX_W-1:0] o_out_index
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_index))
        else $error("result dropped under stall");
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second beat taken while one is in work");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown straight after reset");
endmodule

bind adam_param_update_core apu_checker u_apu_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_out_index
);

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for adam_param_update_core: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import apu_pkg::*;

    localparam int TERMS      = 1024;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 1000;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [GRAD_W-1:0] gm;
        logic signed [GRAD_W-1:0] ge;
        logic                     last;
        bit                       typed;
        logic signed [PARAM_W-1:0] tm;
        logic signed [PARAM_W-1:0] te;
        logic                     tdrop;
    } stim_row_t;

    typedef struct {
        logic [IDX_W-1:0]          idx;
        logic signed [PARAM_W-1:0] pm;
        logic signed [PARAM_W-1:0] pe;
        logic                      drop;
    } upd_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic [IDX_W-1:0] i_term_index = '0;
    logic signed [GRAD_W-1:0] i_grad_mid = '0;
    logic signed [GRAD_W-1:0] i_grad_end = '0;
    logic i_epoch_last = 1'b0;
    logic i_ready = 1'b0;
    wire o_cfg_ready, o_ready, o_valid, o_rate_dropped;
    wire [IDX_W-1:0] o_out_index;
    wire signed [PARAM_W-1:0] o_param_mid, o_param_end;

    adam_param_update_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_term_index(i_term_index), .i_grad_mid(i_grad_mid),
        .i_grad_end(i_grad_end), .i_epoch_last(i_epoch_last),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_index(o_out_index), .o_param_mid(o_param_mid),
        .o_param_end(o_param_end), .o_rate_dropped(o_rate_dropped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of configuration and per-term state
    logic [31:0] grad_scale_q, rate_init_q, rate_now;
    logic [15:0] beta1_q, beta2_q, step_epochs_q, drop_div_q, epoch_no;
    logic signed [GRAD_W-1:0]  mom_q [2][TERMS];
    logic [VEL_W-1:0]          vel_q [2][TERMS];
    logic signed [PARAM_W-1:0] delta_q [2][TERMS];

    upd_res_t expected_updates[$];
    stim_row_t dir_rows[$];
    int n_err = 0, n_in = 0, n_out = 0, n_drops = 0, n_cfg = 0;
    bit quiet = 1'b0;       // no idling on either side
    bit hold_req = 1'b0;    // receiver long hold-off
    int idle_cycles = 0;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [127:0] r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= {64'd0, v}) r = t;
        end
        return r[63:0];
    endfunction

    function automatic logic signed [PARAM_W-1:0] lane_update(int ln, int k,
                                                              logic signed [GRAD_W-1:0] g);
        logic signed [127:0] gw, mag, sc, s, c1, c2, m, q, nv, d, mm, p, st, nd;
        gw = g;
        mag = (gw < 0) ? -gw : gw;
        sc = (mag * $signed({96'd0, grad_scale_q})) >>> 32;
        s = (gw < 0) ? sc : -sc;
        c1 = 128'sd65536 - $signed({112'd0, beta1_q});
        c2 = 128'sd65536 - $signed({112'd0, beta2_q});
        m = ($signed({112'd0, beta1_q}) * mom_q[ln][k] + c1 * s) >>> 16;
        q = (s * s) >>> 32;
        nv = ($signed({112'd0, beta2_q}) * $signed({64'd0, vel_q[ln][k]}) + c2 * q) >>> 16;
        d = $signed({64'd0, isqrt(nv[63:0])}) + 1;
        mm = (m < 0) ? -m : m;
        p = ($signed({96'd0, rate_now}) * mm) >>> 24;
        st = p / d;
        nd = delta_q[ln][k] - ((m < 0) ? -st : st);
        if (nd > 128'sd2147483647) nd = 128'sd2147483647;
        if (nd < -128'sd2147483648) nd = -128'sd2147483648;
        mom_q[ln][k] = m[GRAD_W-1:0];
        vel_q[ln][k] = nv[63:0];
        delta_q[ln][k] = nd[31:0];
        return nd[31:0];
    endfunction

    function automatic upd_res_t predict_update(stim_row_t it);
        upd_res_t r;
        logic [63:0] nr;
        r.idx = it.idx;
        r.pm = lane_update(0, it.idx, it.gm);
        r.pe = lane_update(1, it.idx, it.ge);
        r.drop = 1'b0;
        if (it.last) begin
            if (step_epochs_q != 0 && drop_div_q != 0 && epoch_no % step_epochs_q == 0) begin
                nr = ({32'd0, rate_now} << 8) / drop_div_q;
                rate_now = (nr > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nr[31:0];
                r.drop = 1'b1;
            end
            epoch_no = epoch_no + 16'd1;
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ri;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (ri)
            REG_GRAD_SCALE: grad_scale_q = val;
            REG_BETA_ONE:   beta1_q = val[15:0];
            REG_BETA_TWO:   beta2_q = val[15:0];
            REG_LR_INIT: begin
                rate_init_q = val;
                rate_now = val;
            end
            REG_LR_STEP:    step_epochs_q = val[15:0];
            REG_LR_DIV:     drop_div_q = val[15:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] gs, logic [15:0] b1, logic [15:0] b2,
                            logic [31:0] lr, logic [15:0] st, logic [15:0] dv);
        write_reg(REG_GRAD_SCALE, gs);
        write_reg(REG_BETA_ONE, {16'd0, b1});
        write_reg(REG_BETA_TWO, {16'd0, b2});
        write_reg(REG_LR_INIT, lr);
        write_reg(REG_LR_STEP, {16'd0, st});
        write_reg(REG_LR_DIV, {16'd0, dv});
    endtask

    // valid stays up between back-to-back beats
    task automatic send_item(stim_row_t it);
        upd_res_t r;
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_term_index <= it.idx;
        i_grad_mid   <= it.gm;
        i_grad_end   <= it.ge;
        i_epoch_last <= it.last;
        do @(posedge i_clk); while (!o_ready);
        r = predict_update(it);
        if (it.typed) begin
            r.pm = it.tm;
            r.pe = it.te;
            r.drop = it.tdrop;
        end
        expected_updates.push_back(r);
        n_in++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (expected_updates.size() == 0);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic signed [GRAD_W-1:0] rand_grad();
        logic signed [GRAD_W-1:0] g;
        case ($urandom_range(0, 5))
            0: g = {1'b0, {(GRAD_W-1){1'b1}}};
            1: g = {1'b1, {(GRAD_W-1){1'b0}}};
            2: g = $signed(48'($urandom_range(0, 255))) - 48'sd128;
            3: g = {{16{$urandom_range(0, 1) == 1}}, 32'($urandom)};
            default: g = {16'($urandom), 32'($urandom)};
        endcase
        return g;
    endfunction

    task automatic random_phase(int count, bit with_hold);
        stim_row_t it;
        for (int n = 0; n < count; n++) begin
            it.idx = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, 7))
                                                 : IDX_W'($urandom);
            it.gm = rand_grad();
            it.ge = rand_grad();
            it.last = ($urandom_range(0, 3) == 0);
            it.typed = 1'b0;
            if (with_hold && n == count / 2) hold_req = 1'b1;
            send_item(it);
        end
    endtask

    task automatic add_row(logic [IDX_W-1:0] k, logic signed [GRAD_W-1:0] gm,
                           logic signed [GRAD_W-1:0] ge, logic last, bit typed,
                           logic signed [PARAM_W-1:0] tm, logic signed [PARAM_W-1:0] te);
        stim_row_t r;
        r.idx = k; r.gm = gm; r.ge = ge; r.last = last;
        r.typed = typed; r.tm = tm; r.te = te; r.tdrop = 1'b0;
        dir_rows.push_back(r);
    endtask

    // receiver: random stall per beat, or a long hold-off when asked
    initial begin
        int w;
        forever begin
            @(negedge i_clk);
            i_ready <= 1'b0;
            if (hold_req) begin
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                @(negedge i_clk);
            end else begin
                w = quiet ? 0 : $urandom_range(0, 15);
                repeat (w) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    always @(posedge i_clk) begin
        upd_res_t e;
        if (i_rst_n && o_valid && i_ready) begin
            n_out++;
            if (o_rate_dropped) n_drops++;
            if (expected_updates.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected beat: idx %0d mid %0d end %0d", o_out_index,
                             o_param_mid, o_param_end);
            end else begin
                e = expected_updates.pop_front();
                if (e.idx !== o_out_index || e.pm !== o_param_mid ||
                    e.pe !== o_param_end || e.drop !== o_rate_dropped) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp idx %0d mid %0d end %0d drop %0b / got %0d %0d %0d %0b",
                                 e.idx, e.pm, e.pe, e.drop, o_out_index, o_param_mid,
                                 o_param_end, o_rate_dropped);
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel; covers the clearing pass
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        grad_scale_q = 32'd1; beta1_q = 16'd58982; beta2_q = 16'd65470;
        rate_init_q = 32'd16777216; rate_now = 32'd16777216;
        step_epochs_q = 16'd250; drop_div_q = 16'd256; epoch_no = 16'd1;
        for (int l = 0; l < 2; l++)
            for (int k = 0; k < TERMS; k++) begin
                mom_q[l][k] = '0; vel_q[l][k] = '0; delta_q[l][k] = '0;
            end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fresh terms with zero gradient give zero deltas straight after reset
        add_row(10'd0, 48'sd0, 48'sd0, 1'b0, 1'b1, 32'sd0, 32'sd0);
        add_row(10'd1023, 48'sd0, 48'sd0, 1'b1, 1'b1, 32'sd0, 32'sd0);
        add_row(10'd5, {1'b0, {47{1'b1}}}, {1'b1, {47{1'b0}}}, 1'b0, 1'b0, 0, 0);
        add_row(10'd5, {1'b0, {47{1'b1}}}, {1'b1, {47{1'b0}}}, 1'b0, 1'b0, 0, 0);
        add_row(10'd6, -48'sd1, 48'sd1, 1'b1, 1'b0, 0, 0);
        add_row(10'd7, 48'sh0001_0000_0000, -48'sh0001_0000_0000, 1'b0, 1'b0, 0, 0);
        add_row(10'd7, 48'sh0001_0000_0000, -48'sh0001_0000_0000, 1'b1, 1'b0, 0, 0);
        add_row(10'd512, 48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA, 1'b0, 1'b0, 0, 0);
        foreach (dir_rows[r]) send_item(dir_rows[r]);
        drain();

        // full scale, no decay, maximal rate; a drop every epoch by the largest divisor
        set_regs(32'hFFFF_FFFF, 16'd0, 16'd0, 32'hFFFF_FFFF, 16'd1, 16'd65535);
        dir_rows = {};
        add_row(10'd3, {1'b0, {47{1'b1}}}, {1'b1, {47{1'b0}}}, 1'b1, 1'b0, 0, 0);
        add_row(10'd3, {1'b1, {47{1'b0}}}, {1'b0, {47{1'b1}}}, 1'b1, 1'b0, 0, 0);
        add_row(10'd3, {1'b0, {47{1'b1}}}, {1'b0, {47{1'b1}}}, 1'b0, 1'b0, 0, 0);
        foreach (dir_rows[r]) send_item(dir_rows[r]);
        random_phase(100, 1'b0);
        drain();

        // divisor below one raises the rate until it saturates
        set_regs(32'($urandom), 16'hFFFF, 16'hFFFF, 32'h0100_0000, 16'd2, 16'd128);
        quiet = 1'b1;
        random_phase(100, 1'b1);
        quiet = 1'b0;
        drain();

        // zero step count: never drops
        set_regs(32'h8000_0000, 16'd32768, 16'd65000, 32'h0040_0000, 16'd0, 16'd512);
        random_phase(100, 1'b0);
        drain();

        // zero divisor leaves the rate alone
        set_regs(32'($urandom), 16'($urandom), 16'($urandom), 32'($urandom), 16'd1, 16'd0);
        random_phase(100, 1'b0);
        drain();

        set_regs(32'd1, 16'd58982, 16'd65470, 32'd0, 16'd3, 16'd256);
        random_phase(50, 1'b0);
        drain();
        set_regs(32'($urandom), 16'd58982, 16'd65470, 32'h0100_0000, 16'd65535, 16'd300);
        random_phase(90, 1'b1);
        drain();

        $display("run covered %0d items, %0d results (%0d rate drops), %0d register writes",
                 n_in, n_out, n_drops, n_cfg);
        $display("errors: %0d, results still expected: %0d", n_err, expected_updates.size());
        if (n_err == 0 && expected_updates.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
